[sv/trq_pkg.sv]
// Shared types and screen geometry for the touch report qualifier.
package trq_pkg;

  // Panel geometry (landscape)
  localparam int SCREEN_WIDTH  = 320;
  localparam int SCREEN_HEIGHT = 240;

  // Raw panel range before the flipped-landscape mapping applies
  localparam int RAW_X_MAX = 239;
  localparam int RAW_Y_MAX = 319;

  // Screen toggle button
  localparam int TOGGLE_W = 84;
  localparam int TOGGLE_H = 16;
  localparam int TOGGLE_X = SCREEN_WIDTH - TOGGLE_W - 14;
  localparam int TOGGLE_Y = 34;

  // Row of four action buttons
  localparam int BTN_GAP = 4;
  localparam int BTN_W   = ((SCREEN_WIDTH - 16 - 16) - (3 * BTN_GAP)) / 4;
  localparam int BTN_X0  = 16;
  localparam int BTN_Y   = 173;
  localparam int BTN_H   = 22;
  localparam int BTN_N   = 4;

  // Report decode masks
  localparam logic [7:0] PT_COUNT_MASK = 8'h07;
  localparam logic [7:0] EVENT_MASK    = 8'hC0;
  localparam logic [7:0] NIBBLE_MASK   = 8'h0F;

  // Register reset values
  localparam logic        TOUCH_EN_RST = 1'b1;
  localparam logic [15:0] POLL_IVL_RST = 16'd25;
  localparam logic [15:0] DEBOUNCE_RST = 16'd180;
  localparam logic [15:0] LOCKOUT_RST  = 16'd5000;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_TOUCH_EN = 2'd0,
    REG_POLL_IVL = 2'd1,
    REG_DEBOUNCE = 2'd2,
    REG_LOCKOUT  = 2'd3
  } reg_idx_t;

  // Reported actions
  typedef enum logic [2:0] {
    ACT_NONE    = 3'd0,
    ACT_TOGGLE  = 3'd1,
    ACT_BEACON  = 3'd2,
    ACT_TEST    = 3'd3,
    ACT_APRSPH  = 3'd4,
    ACT_WEATHER = 3'd5,
    ACT_LOG_TAP = 3'd6
  } action_t;

endpackage

[sv/touch_report_qualifier.sv]
// Touch report qualifier: poll gating, report checks, press mapping and hit test.
// Throughput: one item per cycle unless out_stall holds the output; an input
//   register feeds one pass of compares (three 32-bit time differences and the
//   box tests) into the result register.
// Reset (rst, synchronous, active high): registers to their defaults, poll/press/
//   lockout times and the pressed flag to zero, both pipeline stages empty.
module touch_report_qualifier
  import trq_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // configuration write port
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] now_ms,
  input  logic        read_ok,
  input  logic [7:0]  status_byte,
  input  logic [7:0]  x_high_byte,
  input  logic [7:0]  x_low_byte,
  input  logic [7:0]  y_high_byte,
  input  logic [7:0]  y_low_byte,
  input  logic        on_log_screen,
  // output channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  action,
  output logic [8:0]  tap_x,
  output logic [7:0]  tap_y,
  output logic        contact,
  output logic        polled
);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic        touch_enabled;
  logic [15:0] poll_interval_ms;
  logic [15:0] debounce_ms;
  logic [15:0] lockout_ms;

  always_ff @(posedge clk) begin
    if (rst) begin
      touch_enabled    <= TOUCH_EN_RST;
      poll_interval_ms <= POLL_IVL_RST;
      debounce_ms      <= DEBOUNCE_RST;
      lockout_ms       <= LOCKOUT_RST;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_TOUCH_EN: touch_enabled    <= cfg_data[0];
        REG_POLL_IVL: poll_interval_ms <= cfg_data;
        REG_DEBOUNCE: debounce_ms      <= cfg_data;
        REG_LOCKOUT:  lockout_ms       <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake: stage 1 (input register) moves on when the result register is
  // empty or being taken this cycle.
  // ---------------------------------------------------------------------------
  logic s1_valid;
  logic s1_move;
  logic in_take;

  assign s1_move  = !out_valid || !out_stall;
  assign in_stall = s1_valid && !s1_move;
  assign in_take  = in_valid && !in_stall;

  // stage 1 payload
  logic [31:0] s1_now;
  logic        s1_rok;
  logic [7:0]  s1_b2, s1_b3, s1_b4, s1_b5, s1_b6;
  logic        s1_log;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_now <= now_ms;
      s1_rok <= read_ok;
      s1_b2  <= status_byte;
      s1_b3  <= x_high_byte;
      s1_b4  <= x_low_byte;
      s1_b5  <= y_high_byte;
      s1_b6  <= y_low_byte;
      s1_log <= on_log_screen;
    end
  end

  // ---------------------------------------------------------------------------
  // Tracking state. Updated when a stage 1 item with gate_ok moves to the result
  // register, so the next item in stage 1 already sees it.
  // ---------------------------------------------------------------------------
  logic [31:0] last_poll_time;
  logic [31:0] last_press_time;
  logic [31:0] lockout_until;
  logic        was_pressed;

  // ---------------------------------------------------------------------------
  // Qualification logic
  // ---------------------------------------------------------------------------
  logic [31:0] poll_age, press_age, lock_left;
  logic        gate_ok, rpt_ok, deb_ok, lock_active;
  logic [11:0] raw_x, raw_y;
  logic        use_raw, in_bounds;
  logic [8:0]  map_x;
  logic [7:0]  map_y;
  logic        press;
  logic        hit_toggle;
  logic [BTN_N-1:0] hit_btn;
  action_t     act;
  logic        btn_fire;

  assign poll_age  = s1_now - last_poll_time;
  assign press_age = s1_now - last_press_time;
  assign lock_left = lockout_until - s1_now;

  assign gate_ok = touch_enabled && (poll_age >= {16'd0, poll_interval_ms});

  // all-zero / all-FF reports, no points, or both event bits set are rejected
  assign rpt_ok = s1_rok
               && !(s1_b2 == 8'h00 && s1_b3 == 8'h00 && s1_b4 == 8'h00 && s1_b6 == 8'h00)
               && !(s1_b2 == 8'hFF && s1_b3 == 8'hFF && s1_b4 == 8'hFF && s1_b6 == 8'hFF)
               && ((s1_b2 & PT_COUNT_MASK) != 8'h00)
               && ((s1_b3 & EVENT_MASK) != EVENT_MASK);

  assign deb_ok = press_age >= {16'd0, debounce_ms};
  // lockout holds while the signed remainder is positive
  assign lock_active = (lock_left != 32'd0) && !lock_left[31];

  assign raw_x = {s1_b3[3:0], s1_b4};
  assign raw_y = {s1_b5[3:0], s1_b6};

  // Outside the expected panel range the raw point is used as is
  assign use_raw = (raw_x > 12'(RAW_X_MAX)) || (raw_y > 12'(RAW_Y_MAX));
  // Flipped mapping of an in-range point always lands on screen
  assign in_bounds = !use_raw
                  || ((raw_x < 12'(SCREEN_WIDTH)) && (raw_y < 12'(SCREEN_HEIGHT)));

  always_comb begin
    logic [11:0] flip_x;
    flip_x = 12'(SCREEN_WIDTH - 1) - raw_y;
    if (use_raw) begin
      map_x = raw_x[8:0];
      map_y = raw_y[7:0];
    end else begin
      map_x = flip_x[8:0];
      map_y = raw_x[7:0];
    end
  end

  assign press = gate_ok && rpt_ok && !was_pressed && deb_ok && !lock_active && in_bounds;

  // Hit tests against the main-screen buttons
  assign hit_toggle = (map_x >= 9'(TOGGLE_X)) && (map_x < 9'(TOGGLE_X + TOGGLE_W))
                   && (map_y >= 8'(TOGGLE_Y)) && (map_y < 8'(TOGGLE_Y + TOGGLE_H));

  always_comb begin
    for (int k = 0; k < BTN_N; k++) begin
      hit_btn[k] = ({1'b0, map_x} >= 10'(BTN_X0 + k * (BTN_W + BTN_GAP)))
                && ({1'b0, map_x} < 10'(BTN_X0 + k * (BTN_W + BTN_GAP) + BTN_W))
                && (map_y >= 8'(BTN_Y)) && (map_y < 8'(BTN_Y + BTN_H));
    end
  end

  always_comb begin
    act = ACT_NONE;
    if (press) begin
      if (s1_log) begin
        act = ACT_LOG_TAP;
      end else if (hit_toggle) begin
        act = ACT_TOGGLE;
      end else if (hit_btn[0]) begin
        act = ACT_BEACON;
      end else if (hit_btn[1]) begin
        act = ACT_TEST;
      end else if (hit_btn[2]) begin
        act = ACT_APRSPH;
      end else if (hit_btn[3]) begin
        act = ACT_WEATHER;
      end
    end
  end

  // one of the four action buttons arms the lockout
  assign btn_fire = (act == ACT_BEACON) || (act == ACT_TEST)
                 || (act == ACT_APRSPH) || (act == ACT_WEATHER);

  // ---------------------------------------------------------------------------
  // State update and result register
  // ---------------------------------------------------------------------------
  logic s1_fire;
  assign s1_fire = s1_valid && s1_move;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_poll_time  <= 32'd0;
      last_press_time <= 32'd0;
      lockout_until   <= 32'd0;
      was_pressed     <= 1'b0;
    end else if (s1_fire && gate_ok) begin
      last_poll_time <= s1_now;
      was_pressed    <= rpt_ok;
      if (press) begin
        last_press_time <= s1_now;
      end
      if (btn_fire) begin
        lockout_until <= s1_now + {16'd0, lockout_ms};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_move) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      action  <= act;
      tap_x   <= (act != ACT_NONE) ? map_x : 9'd0;
      tap_y   <= (act != ACT_NONE) ? map_y : 8'd0;
      contact <= gate_ok && rpt_ok;
      polled  <= gate_ok;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_action_needs_contact: assert property (@(posedge clk) disable iff (rst)
    out_valid && (action != ACT_NONE) |-> contact && polled)
    else $error("action reported without a valid polled contact");

  a_contact_needs_poll: assert property (@(posedge clk) disable iff (rst)
    out_valid && contact |-> polled)
    else $error("contact reported on a gated poll");

  a_idle_coords_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (action == ACT_NONE) |-> (tap_x == 9'd0) && (tap_y == 8'd0))
    else $error("tap coordinates nonzero with no action");

  a_stage1_holds: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_move |=> s1_valid && $stable(s1_now))
    else $error("stage 1 item lost while the output is stalled");

endmodule
